/* rtl/pfifo_pkg.sv */
package pfifo_pkg;

    localparam int PFIFO_SLOTS      = 16;
    localparam int PFIFO_SLOT_BYTES = 64;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_OK        = 3'd2,
        ST_REJECT    = 3'd3,
        ST_OVERWRITE = 3'd4,
        ST_TRUNC     = 3'd5
    } t_status;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       in_last;
        logic       force_req;
        logic [6:0] read_limit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [2:0] status;
        logic [6:0] copied_length;
        logic [6:0] head_length;
        logic [4:0] packet_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOOK,
        S_EMIT,
        S_RADDR,
        S_ROUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_single;
        logic load_byte;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_stream;
        logic last_byte;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/packet_fifo_overwrite_oldest.sv */
// Packet FIFO with SLOTS fixed slots of SLOT_BYTES bytes. A write
// transaction carries one byte; the byte with in_last set commits the
// packet. If all slots hold packets when a packet starts, the packet is
// rejected, or with force_req on its first byte the oldest packet is
// dropped and its slot reused. Bytes past SLOT_BYTES are dropped and the
// packet reports truncated. A read transaction returns the oldest packet,
// cut to read_limit bytes, one result per byte, and frees its slot; an
// empty FIFO or a zero limit gives one result. Every write gets one
// result with the packet's outcome so far. Items are handled one at a
// time, each accepted, executed and followed by a length lookup; then a
// write, an empty read or a zero-length read gives its one result, and a
// read with bytes streams them. An output stall holds the sequence. The
// steps come from the single registered read ports of the byte store
// and the length table: the new head's length is looked up after each
// update, and each streamed byte is a read, then an output register load.
module packet_fifo_overwrite_oldest #(
    parameter int SLOTS      = pfifo_pkg::PFIFO_SLOTS,
    parameter int SLOT_BYTES = pfifo_pkg::PFIFO_SLOT_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pfifo_pkg::t_in_item  i_in_item,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pfifo_pkg::t_out_item o_out_item
);
    import pfifo_pkg::*;

    // command / status between sequencer and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: accept, execute, length lookup, then one result or a
    // byte stream
    pfifo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    // datapath: slot memories, head/tail/count, packet state and the
    // output register
    pfifo_dp #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* rtl/pfifo_ctrl.sv */
module pfifo_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output pfifo_pkg::t_dp_cmd o_cmd,
    input  pfifo_pkg::t_dp_stat i_stat
);
    import pfifo_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOOK;
            end
            // waits for the registered length table read at the new head
            S_LOOK: begin
                n_state = i_stat.is_stream ? S_RADDR : S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_single = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_RADDR: begin
                n_state = S_ROUT;
            end
            S_ROUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    n_state         = i_stat.last_byte ? S_IDLE : S_RADDR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/pfifo_dp.sv */
module pfifo_dp #(
    parameter int SLOTS      = pfifo_pkg::PFIFO_SLOTS,
    parameter int SLOT_BYTES = pfifo_pkg::PFIFO_SLOT_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pfifo_pkg::t_in_item  i_in_item,
    input  pfifo_pkg::t_dp_cmd   i_cmd,
    output pfifo_pkg::t_dp_stat  o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pfifo_pkg::t_out_item o_out_item
);
    import pfifo_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = $clog2(SLOT_BYTES + 1);
    localparam int BW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int MEM_DEPTH = SLOTS << BW;

    // storage
    logic [7:0]    byte_mem [MEM_DEPTH];
    logic [LW-1:0] len_mem  [SLOTS];
    logic [7:0]    r_byte_rd;
    logic [LW-1:0] r_len_rd;

    // queue state
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] r_cursor, n_cursor;
    logic          r_open, n_open;
    t_status       r_outcome, n_outcome;

    // per-transaction state
    t_in_item      r_item;
    t_status       r_status, n_status;
    logic          r_stream, n_stream;
    logic [LW-1:0] r_n, n_n;
    logic [SW-1:0] r_slot, n_slot;
    logic [LW-1:0] r_idx, n_idx;

    logic               r_out_valid;
    t_out_item          r_out;
    logic               byte_we;
    logic [SW+BW-1:0]   byte_waddr;
    logic               len_we;
    logic [LW-1:0]      len_wdata;
    logic [SW-1:0]      head_next;
    logic [SW-1:0]      tail_next;
    logic [6:0]         len7;
    logic [6:0]         copy_n;
    logic [6:0]         head_len_out;
    logic [4:0]         count_out;

    assign head_next = (r_head == SW'(SLOTS - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == SW'(SLOTS - 1)) ? '0 : r_tail + 1'b1;

    // bytes to copy: min(length, limit), never past a slot
    always_comb begin
        len7   = 7'(r_len_rd);
        copy_n = (len7 < r_item.read_limit) ? len7 : r_item.read_limit;
        if (copy_n > 7'(SLOT_BYTES)) begin
            copy_n = 7'(SLOT_BYTES);
        end
    end

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_open     = r_open;
        n_outcome  = r_outcome;
        n_status   = r_status;
        n_stream   = r_stream;
        n_n        = r_n;
        n_slot     = r_slot;
        n_idx      = r_idx;
        byte_we    = 1'b0;
        byte_waddr = {r_tail, r_cursor[BW-1:0]};
        len_we     = 1'b0;
        len_wdata  = r_cursor;
        if (i_cmd.exec) begin
            if (r_item.cmd == CMD_WRITE) begin
                if (!r_open) begin
                    n_open   = 1'b1;
                    n_cursor = '0;
                    if (r_count < CW'(SLOTS)) begin
                        n_outcome = ST_OK;
                    end else if (r_item.force_req) begin
                        n_head    = head_next;
                        n_count   = r_count - 1'b1;
                        n_outcome = ST_OVERWRITE;
                    end else begin
                        n_outcome = ST_REJECT;
                    end
                end
                if (n_outcome != ST_REJECT) begin
                    if (n_cursor < LW'(SLOT_BYTES)) begin
                        byte_we    = 1'b1;
                        byte_waddr = {r_tail, n_cursor[BW-1:0]};
                        n_cursor   = n_cursor + 1'b1;
                    end else begin
                        n_outcome = ST_TRUNC;
                    end
                end
                n_status = n_outcome;
                n_stream = 1'b0;
                if (r_item.in_last) begin
                    if (n_outcome != ST_REJECT) begin
                        len_we    = 1'b1;
                        len_wdata = n_cursor;
                        n_tail    = tail_next;
                        n_count   = n_count + 1'b1;
                    end
                    n_open   = 1'b0;
                    n_cursor = '0;
                end
            end else if (r_count == '0) begin
                n_status = ST_EMPTY;
                n_stream = 1'b0;
            end else begin
                n_n      = LW'(copy_n);
                n_slot   = r_head;
                n_idx    = '0;
                n_head   = head_next;
                n_count  = r_count - 1'b1;
                n_status = ST_DATA;
                n_stream = (copy_n != '0);
            end
        end
        if (i_cmd.load_byte) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_cursor  <= '0;
            r_open    <= 1'b0;
            r_outcome <= ST_DATA;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_open    <= n_open;
            r_outcome <= n_outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        r_status <= n_status;
        r_stream <= n_stream;
        r_n      <= n_n;
        r_slot   <= n_slot;
        r_idx    <= n_idx;
    end

    // memories, registered read ports
    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            byte_mem[byte_waddr] <= r_item.data_byte;
        end
        r_byte_rd <= byte_mem[{r_slot, r_idx[BW-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[r_tail] <= len_wdata;
        end
        r_len_rd <= len_mem[r_head];
    end

    // output register
    assign head_len_out = (r_count == '0) ? '0 : 7'(r_len_rd);
    assign count_out    = 5'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_single || i_cmd.load_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_out.out_byte      <= '0;
            r_out.out_last      <= 1'b1;
            r_out.status        <= r_status;
            r_out.copied_length <= '0;
            r_out.head_length   <= head_len_out;
            r_out.packet_count  <= count_out;
        end else if (i_cmd.load_byte) begin
            r_out.out_byte      <= r_byte_rd;
            r_out.out_last      <= o_stat.last_byte;
            r_out.status        <= ST_DATA;
            r_out.copied_length <= 7'(r_n);
            r_out.head_length   <= head_len_out;
            r_out.packet_count  <= count_out;
        end
    end

    assign o_stat.is_stream = r_stream;
    assign o_stat.last_byte = ((r_idx + 1'b1) == r_n);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;

endmodule
